FILE: rtl/approx_suffix_prefix_overlap_macros.svh
// Assertion macros used by the top RTL file of the overlap block.
`ifndef APPROX_SUFFIX_PREFIX_OVERLAP_MACROS_SVH
`define APPROX_SUFFIX_PREFIX_OVERLAP_MACROS_SVH

`ifndef SYNTHESIS
`define ASP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("overlap block check failed");
`define ASP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("overlap block reset check failed");
`else
`define ASP_ASSERT(lbl, prop)
`define ASP_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/asp_pkg.sv
package asp_pkg;

    localparam int MAX_LEN_DEF = 128;
    localparam int CHAR_W      = 8;
    localparam int OVL_W       = 8;
    localparam int MIN_OVL_W   = 8;
    localparam int MAX_ERR_W   = 4;
    localparam int ERR_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_OVERLAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS  = 2'd1;

    localparam logic [MIN_OVL_W-1:0] MIN_OVERLAP_RST = 8'd12;
    localparam logic [MAX_ERR_W-1:0] MAX_ERRORS_RST  = 4'd2;

    // Mismatch counters stop one above the largest allowed error limit.
    localparam logic [ERR_W-1:0] ERR_SAT = 5'd16;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_SCAN = 2'b10
    } asp_state_t;

    typedef struct packed {
        logic load;
        logic drain;
        logic clear;
    } asp_ctrl_t;

endpackage

FILE: rtl/asp_cell.sv
module asp_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  asp_pkg::asp_ctrl_t          ctrl,
    input  logic [asp_pkg::CHAR_W-1:0]  a_char,
    input  logic [asp_pkg::CHAR_W-1:0]  b_in,
    input  logic                        vld_in,
    input  logic [asp_pkg::ERR_W-1:0]   cnt_in,
    output logic [asp_pkg::CHAR_W-1:0]  b_out,
    output logic                        vld_out,
    output logic [asp_pkg::ERR_W-1:0]   cnt_out
);

    logic [asp_pkg::CHAR_W-1:0] b_reg, b_next;
    logic                       vld_reg, vld_next;
    logic [asp_pkg::ERR_W-1:0]  cnt_reg, cnt_next;

    // The cell compares the broadcast A character with the B character that
    // has travelled this far down the line, i.e. B shifted by the cell's place.
    always_comb begin
        b_next   = b_reg;
        vld_next = vld_reg;
        cnt_next = cnt_reg;
        if (ctrl.clear) begin
            vld_next = 1'b0;
            cnt_next = '0;
        end else if (ctrl.load) begin
            b_next   = b_in;
            vld_next = vld_in;
            if (vld_in && (a_char != b_in) && (cnt_reg != asp_pkg::ERR_SAT)) begin
                cnt_next = cnt_reg + asp_pkg::ERR_W'(1);
            end
        end else if (ctrl.drain) begin
            cnt_next = cnt_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg <= b_next;
    end

    assign b_out   = b_reg;
    assign vld_out = vld_reg;
    assign cnt_out = cnt_reg;

endmodule

FILE: rtl/asp_chain.sv
module asp_chain #(
    parameter int MAX_LEN = asp_pkg::MAX_LEN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  asp_pkg::asp_ctrl_t          ctrl,
    input  logic [asp_pkg::CHAR_W-1:0]  a_char,
    input  logic [asp_pkg::CHAR_W-1:0]  b_char,
    output logic [asp_pkg::ERR_W-1:0]   head_cnt
);

    logic [asp_pkg::CHAR_W-1:0] b_link   [0:MAX_LEN-1];
    logic                       vld_link [0:MAX_LEN-1];
    logic [asp_pkg::ERR_W-1:0]  cnt_link [0:MAX_LEN];

    assign b_link[0]         = b_char;
    assign vld_link[0]       = 1'b1;
    assign cnt_link[MAX_LEN] = '0;
    assign head_cnt          = cnt_link[0];

    // B characters move away from the head while loading; the finished
    // counts move towards the head while the result is searched.
    for (genvar s = 0; s < MAX_LEN; s++) begin : g_cell
        if (s < MAX_LEN - 1) begin : g_mid
            asp_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .a_char  (a_char),
                .b_in    (b_link[s]),
                .vld_in  (vld_link[s]),
                .cnt_in  (cnt_link[s+1]),
                .b_out   (b_link[s+1]),
                .vld_out (vld_link[s+1]),
                .cnt_out (cnt_link[s])
            );
        end else begin : g_end
            asp_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .a_char  (a_char),
                .b_in    (b_link[s]),
                .vld_in  (vld_link[s]),
                .cnt_in  (cnt_link[s+1]),
                .b_out   (),
                .vld_out (),
                .cnt_out (cnt_link[s])
            );
        end
    end

endmodule

FILE: rtl/approx_suffix_prefix_overlap.sv
// Channel  Direction  Beat contents
// s_       in         tdata: a_char [7:0], b_char [15:8]; tlast: last pair of the reads
// m_       out        tdata: overlap_length [7:0]; tuser: too_long
// cfg_     in         cfg_index selects the register, cfg_data carries its value
//
// A pair of reads loads one beat per cycle and is then searched, one shift per cycle as
// the mismatch counts of the cell chain move to its head.
// Synchronous active-low reset; no clearing pass, the chain is cleared as a result enters the output register.
// Loading of the next reads may proceed while a result waits on m_tready; the search
// only finishes once the output register is free.
`include "approx_suffix_prefix_overlap_macros.svh"

module approx_suffix_prefix_overlap #(
    parameter int MAX_LEN = asp_pkg::MAX_LEN_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [2*asp_pkg::CHAR_W-1:0]         s_tdata,   // a_char, b_char
    input  logic                                 s_tlast,   // last
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [asp_pkg::OVL_W-1:0]            m_tdata,   // overlap_length
    output logic                                 m_tuser,   // too_long
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [asp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [asp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W = (CNT_W > asp_pkg::MIN_OVL_W) ? CNT_W : asp_pkg::MIN_OVL_W;

    asp_pkg::asp_state_t state_reg, state_next;

    logic [asp_pkg::MIN_OVL_W-1:0] min_overlap_reg, min_overlap_next;
    logic [asp_pkg::MAX_ERR_W-1:0] max_errors_reg, max_errors_next;
    logic [CNT_W-1:0]              len_reg, len_next;
    logic                          ovf_reg, ovf_next;
    logic [CNT_W-1:0]              scan_reg, scan_next;
    logic [CNT_W-1:0]              lim_reg, lim_next;
    logic                          fail_reg, fail_next;
    logic                          out_valid_reg, out_valid_next;
    logic [asp_pkg::OVL_W-1:0]     out_len_reg, out_len_next;
    logic                          out_long_reg, out_long_next;

    asp_pkg::asp_ctrl_t          ctrl;
    logic [asp_pkg::ERR_W-1:0]   head_cnt;
    logic                        s_fire;
    logic                        full;
    logic                        out_free;
    logic                        hit;
    logic                        stop;
    logic                        finish;
    logic [CMP_W-1:0]            len_new;
    logic [CMP_W-1:0]            mo_eff;
    logic [CMP_W-1:0]            diff;

    assign s_tready  = (state_reg == asp_pkg::ST_LOAD);
    assign s_fire    = s_tvalid && s_tready;
    assign full      = (len_reg == CNT_W'(MAX_LEN));
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // A zero minimum behaves as one: a zero-length overlap reports zero anyway.
    assign mo_eff  = (min_overlap_reg == '0) ? CMP_W'(1) : CMP_W'(min_overlap_reg);
    assign len_new = full ? CMP_W'(len_reg) : CMP_W'(len_reg) + CMP_W'(1);

    assign hit    = !fail_reg && ({1'b0, max_errors_reg} >= head_cnt);
    assign stop   = fail_reg || hit || (scan_reg == lim_reg);
    assign finish = (state_reg == asp_pkg::ST_SCAN) && stop && out_free;
    assign diff   = CMP_W'(len_reg) - CMP_W'(scan_reg);

    assign ctrl.load  = s_fire && !full;
    assign ctrl.drain = (state_reg == asp_pkg::ST_SCAN) && !stop;
    assign ctrl.clear = finish;

    always_comb begin
        min_overlap_next = min_overlap_reg;
        max_errors_next  = max_errors_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                asp_pkg::REG_MIN_OVERLAP: min_overlap_next = cfg_data;
                asp_pkg::REG_MAX_ERRORS:  max_errors_next  = cfg_data[asp_pkg::MAX_ERR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        scan_next      = scan_reg;
        lim_next       = lim_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_len_next   = out_len_reg;
        out_long_next  = out_long_reg;
        case (state_reg)
            asp_pkg::ST_LOAD: begin
                if (s_fire) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        len_next = len_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        fail_next  = (mo_eff > len_new);
                        lim_next   = CNT_W'(len_new - mo_eff);
                        scan_next  = '0;
                        state_next = asp_pkg::ST_SCAN;
                    end
                end
            end
            asp_pkg::ST_SCAN: begin
                if (finish) begin
                    out_valid_next = 1'b1;
                    out_len_next   = hit ? diff[asp_pkg::OVL_W-1:0] : '0;
                    out_long_next  = ovf_reg;
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    scan_next      = '0;
                    state_next     = asp_pkg::ST_LOAD;
                end else if (!stop) begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            default: begin
                state_next = asp_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= asp_pkg::ST_LOAD;
            min_overlap_reg <= asp_pkg::MIN_OVERLAP_RST;
            max_errors_reg  <= asp_pkg::MAX_ERRORS_RST;
            len_reg         <= '0;
            ovf_reg         <= 1'b0;
            scan_reg        <= '0;
            lim_reg         <= '0;
            fail_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            min_overlap_reg <= min_overlap_next;
            max_errors_reg  <= max_errors_next;
            len_reg         <= len_next;
            ovf_reg         <= ovf_next;
            scan_reg        <= scan_next;
            lim_reg         <= lim_next;
            fail_reg        <= fail_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_len_reg  <= out_len_next;
        out_long_reg <= out_long_next;
    end

    asp_chain #(
        .MAX_LEN (MAX_LEN)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .a_char   (s_tdata[asp_pkg::CHAR_W-1:0]),
        .b_char   (s_tdata[2*asp_pkg::CHAR_W-1:asp_pkg::CHAR_W]),
        .head_cnt (head_cnt)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_len_reg;
    assign m_tuser  = out_long_reg;

    `ASP_ASSERT(a_last_stops_input, (s_fire && s_tlast) |=> !s_tready)
    `ASP_ASSERT(a_scan_in_range, (state_reg == asp_pkg::ST_SCAN && !fail_reg) |-> (scan_reg <= lim_reg))
    `ASP_ASSERT(a_load_scan_idle, (state_reg == asp_pkg::ST_LOAD) |-> (scan_reg == '0))
    `ASP_ASSERT_RST(a_reset_empties, !aresetn |=> (!m_tvalid && len_reg == '0))

endmodule
